@@ rtl/core/ssq_pkg.sv @@
`timescale 1ns / 1ps

package ssq_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_PATTERN  = 3'd0;
  localparam logic [2:0] CFG_QUANTIZE = 3'd1;
  localparam logic [2:0] CFG_SPAN     = 3'd2;
  localparam logic [2:0] CFG_SHIFT    = 3'd3;
  localparam logic [2:0] CFG_MASK     = 3'd4;
  localparam logic [2:0] CFG_SEED     = 3'd5;

  // Pattern modes
  localparam logic [1:0] PAT_LOOP   = 2'd0;
  localparam logic [1:0] PAT_BOUNCE = 2'd1;
  localparam logic [1:0] PAT_RANDOM = 2'd2;
  localparam logic [1:0] PAT_HOLD   = 2'd3;

  // Quantizer modes
  localparam logic [1:0] QNT_NONE  = 2'd0;
  localparam logic [1:0] QNT_CHROM = 2'd1;
  localparam logic [1:0] QNT_MAJOR = 2'd2;
  localparam logic [1:0] QNT_MINOR = 2'd3;

  // Octave spans
  localparam logic [1:0] SPAN_ONE  = 2'd0;
  localparam logic [1:0] SPAN_TWO  = 2'd1;
  localparam logic [1:0] SPAN_FIVE = 2'd2;

  // Request kinds carried on tuser
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RD_NOW,
    ST_RD_NEXT,
    ST_FILL1,
    ST_FILL2,
    ST_FILL3,
    ST_OUT
  } ssq_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_wr;     // store the accepted sample
    logic adv_start;   // pending step becomes playing step
    logic search_try;  // one try of the next-step search
    logic rd_now;      // read sample of playing step
    logic rd_next;     // read sample of pending step
    logic cap_now;     // capture DAC code of playing step
    logic cap_next;    // capture DAC code of pending step
    logic out_load;    // move finished result into output register
  } ssq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hold_pending;  // pattern leaves pending step as is
    logic search_last;   // current try ends the search
  } ssq_stat_t;

endpackage

@@ rtl/core/ssq_ram.sv @@
`timescale 1ns / 1ps

module ssq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/ssq_ctrl.sv @@
`timescale 1ns / 1ps

module ssq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_req,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ssq_pkg::ssq_stat_t stat,
  output ssq_pkg::ssq_cmd_t  cmd
);

  import ssq_pkg::*;

  ssq_state_t state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_tready      = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_req == REQ_ADVANCE) begin
            cmd.adv_start = 1'b1;
            state_nxt     = stat.hold_pending ? ST_RD_NOW : ST_SEARCH;
          end else begin
            cmd.load_wr = 1'b1;
            state_nxt   = ST_RD_NOW;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search_try = 1'b1;
        if (stat.search_last) begin
          state_nxt = ST_RD_NOW;
        end
      end
      ST_RD_NOW: begin
        cmd.rd_now = 1'b1;
        state_nxt  = ST_RD_NEXT;
      end
      ST_RD_NEXT: begin
        cmd.rd_next = 1'b1;
        state_nxt   = ST_FILL1;
      end
      ST_FILL1: begin
        state_nxt = ST_FILL2;
      end
      ST_FILL2: begin
        cmd.cap_now = 1'b1;
        state_nxt   = ST_FILL3;
      end
      ST_FILL3: begin
        cmd.cap_next = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over a word not yet taken");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted word");

  a_cap_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_next |=> (state_r == ST_OUT))
    else $error("second code captured but no output state follows");

endmodule

@@ rtl/core/ssq_dp.sv @@
`timescale 1ns / 1ps

module ssq_dp #(
  parameter int STEPS    = 8,
  parameter int DAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssq_pkg::ssq_cmd_t  cmd,
  output ssq_pkg::ssq_stat_t stat,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [2:0]         in_step_index,
  input  logic [11:0]        in_cv_sample,
  output logic [2:0]         out_current_step,
  output logic [2:0]         out_next_step,
  output logic [11:0]        out_cv_now,
  output logic [11:0]        out_cv_next
);

  import ssq_pkg::*;

  localparam int IW    = $clog2(STEPS);
  localparam int TW    = $clog2(STEPS + 1);
  localparam int S     = DAC_BITS - 10;
  localparam int BLOCK = 204 << S;
  localparam int SEMI  = 17 << S;
  localparam int BASE  = 2 << S;
  localparam int TOP   = (1 << DAC_BITS) - 1;
  localparam int BW    = $clog2(5 * BLOCK + 1);
  localparam int PW    = 12 + BW;
  localparam int VW    = PW - 11;
  localparam int SW    = VW + 3;

  // Configuration registers
  logic [1:0]        pattern_r;
  logic [1:0]        quant_r;
  logic [1:0]        span_r;
  logic signed [2:0] shift_r;
  logic [7:0]        mask_r;

  // Sequencer state
  logic [IW-1:0]    playing_r;
  logic [IW-1:0]    pending_r;
  logic             bounce_r;
  logic [31:0]      rng_r;
  logic [TW-1:0]    tries_r;
  logic [STEPS-1:0] vld_r;

  // Search helpers
  logic [IW-1:0] k_new;
  logic          bd_new;
  logic [31:0]   rng_step;
  logic [31:0]   rng_new;
  logic [IW-1:0] rnd_k;
  logic [3:0]    kx;
  logic          k_en;

  // Sample memory and scaler pipeline
  logic          load_ok;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;
  logic [11:0]   rd_data;
  logic          vld_q_r;
  logic [11:0]   samp_eff;
  logic [BW-1:0] blkm;
  logic [PW-1:0] prod_r;
  logic [PW:0]   vsum;
  logic [VW-1:0] v_cur;
  logic [9:0]    xq;
  logic [VW-1:0] v_r;
  logic [21:0]   qm_r;
  logic [5:0]    n_raw;
  logic [5:0]    n_adj;
  logic [VW-1:0] vq;
  logic [VW-1:0] vsel;
  logic signed [SW-1:0] vsum_s;
  logic [11:0]   code;
  logic [11:0]   cv_now_r;
  logic [11:0]   cv_next_r;
  logic [2:0]    cur_out_r;
  logic [2:0]    nxt_out_r;
  logic [11:0]   cvn_out_r;
  logic [11:0]   cvx_out_r;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  assign rng_step = xorshift32(rng_r);

  // Random index: rng modulo STEPS
  generate
    if ((STEPS & (STEPS - 1)) == 0) begin : g_rnd_pow2
      assign rnd_k = rng_step[IW-1:0];
    end else begin : g_rnd_fold
      localparam int RECIP = (1 << 20) / STEPS + 1;
      localparam int NW [8] = '{1 % STEPS, 16 % STEPS, 256 % STEPS, 4096 % STEPS,
                                65536 % STEPS, 1048576 % STEPS,
                                16777216 % STEPS, 268435456 % STEPS};
      logic [10:0] fsum;
      logic [31:0] fq;
      logic [10:0] frem;
      // nibble residues folded into an 11-bit sum
      always_comb begin
        fsum = '0;
        for (int i = 0; i < 8; i++) begin
          fsum = fsum + 11'(int'(rng_step[4*i +: 4]) * NW[i]);
        end
      end
      assign fq    = ({21'b0, fsum} * 32'(RECIP)) >> 20;
      assign frem  = fsum - 11'(fq[10:0] * 11'(STEPS));
      assign rnd_k = IW'(frem);
    end
  endgenerate

  // Candidate step for one search try
  always_comb begin
    k_new   = pending_r;
    bd_new  = bounce_r;
    rng_new = rng_r;
    case (pattern_r)
      PAT_LOOP: begin
        k_new = (pending_r == IW'(STEPS - 1)) ? '0 : pending_r + 1'b1;
      end
      PAT_BOUNCE: begin
        if (!bounce_r && pending_r == IW'(STEPS - 1)) begin
          bd_new = 1'b1;
        end else if (bounce_r && pending_r == '0) begin
          bd_new = 1'b0;
        end
        k_new = bd_new ? pending_r - 1'b1 : pending_r + 1'b1;
        if (k_new == IW'(STEPS - 1)) begin
          bd_new = 1'b1;
        end else if (k_new == '0) begin
          bd_new = 1'b0;
        end
      end
      PAT_RANDOM: begin
        rng_new = rng_step;
        k_new   = rnd_k;
      end
      default: begin
        k_new = pending_r;
      end
    endcase
  end

  // Step indexes of eight and above have no mask bit and count as enabled
  assign kx   = 4'(k_new);
  assign k_en = kx[3] | mask_r[kx[2:0]];

  assign stat.hold_pending = (pattern_r == PAT_HOLD);
  assign stat.search_last  = k_en || (tries_r == TW'(STEPS - 1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PAT_LOOP;
      quant_r   <= QNT_NONE;
      span_r    <= SPAN_ONE;
      shift_r   <= '0;
      mask_r    <= 8'hFF;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_PATTERN:  pattern_r <= cfg_data[1:0];
        CFG_QUANTIZE: quant_r   <= cfg_data[1:0];
        CFG_SPAN:     span_r    <= cfg_data[1:0];
        CFG_SHIFT:    shift_r   <= $signed(cfg_data[2:0]);
        CFG_MASK:     mask_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Step state, search and random generator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= '0;
      pending_r <= '0;
      bounce_r  <= 1'b0;
      rng_r     <= 32'd2;
      tries_r   <= '0;
    end else begin
      if (cmd.adv_start) begin
        playing_r <= pending_r;
        tries_r   <= '0;
      end
      if (cmd.search_try) begin
        pending_r <= k_new;
        bounce_r  <= bd_new;
        tries_r   <= tries_r + 1'b1;
      end
      if (cfg_wr && cfg_index == CFG_SEED) begin
        rng_r <= (cfg_data == 32'd0) ? 32'd2 : cfg_data;
      end else if (cmd.search_try) begin
        rng_r <= rng_new;
      end
    end
  end

  // Sample store: unwritten steps read as zero
  assign load_ok = ({2'b0, in_step_index} < 5'(STEPS));
  assign wr_addr = IW'(in_step_index);
  assign rd_addr = cmd.rd_now ? playing_r : pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.load_wr && load_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_now || cmd.rd_next) begin
      vld_q_r <= vld_r[rd_addr];
    end
  end

  ssq_ram #(
    .WIDTH(12),
    .DEPTH(STEPS)
  ) u_samples (
    .clk    (clk),
    .wr_en  (cmd.load_wr && load_ok),
    .wr_addr(wr_addr),
    .wr_data(in_cv_sample),
    .rd_en  (cmd.rd_now || cmd.rd_next),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign samp_eff = vld_q_r ? rd_data : 12'd0;

  // Stage 1: sample times block size times span
  always_comb begin
    case (span_r)
      SPAN_TWO:  blkm = BW'(2 * BLOCK);
      SPAN_FIVE: blkm = BW'(5 * BLOCK);
      default:   blkm = BW'(BLOCK);
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {{BW{1'b0}}, samp_eff} * {{12{1'b0}}, blkm};
  end

  // Stage 2: round to DAC units, semitone quotient by reciprocal of 17
  assign vsum  = {1'b0, prod_r} + (PW + 1)'(2048);
  assign v_cur = vsum[PW:12];
  assign xq    = 10'(v_cur >> S);

  always_ff @(posedge clk) begin
    v_r  <= v_cur;
    qm_r <= {12'b0, xq} * 22'd3856;
  end

  // Stage 3: scale snap, octave offsets and clamp
  assign n_raw = qm_r[21:16];

  always_comb begin
    n_adj = n_raw;
    case (quant_r)
      QNT_MAJOR: begin
        if (n_raw == 6'd1 || n_raw == 6'd3 || n_raw == 6'd6 ||
            n_raw == 6'd8 || n_raw == 6'd10) begin
          n_adj = n_raw + 6'd1;
        end
      end
      QNT_MINOR: begin
        if (n_raw == 6'd1 || n_raw == 6'd4 || n_raw == 6'd6 ||
            n_raw == 6'd9 || n_raw == 6'd11) begin
          n_adj = n_raw + 6'd1;
        end
      end
      default: n_adj = n_raw;
    endcase
  end

  assign vq   = {{(VW - 6){1'b0}}, n_adj} * VW'(SEMI);
  assign vsel = (quant_r != QNT_NONE) ? vq : v_r;

  always_comb begin
    vsum_s = $signed({3'b0, vsel}) + SW'(BASE) + SW'(int'(shift_r) * BLOCK);
    if (span_r != SPAN_FIVE) begin
      vsum_s = vsum_s + SW'(2 * BLOCK);
    end
  end

  assign code = (vsum_s < 0) ? 12'd0 :
                (vsum_s > SW'(TOP)) ? 12'(TOP) : 12'(vsum_s);

  // Captured codes and output register
  always_ff @(posedge clk) begin
    if (cmd.cap_now) begin
      cv_now_r <= code;
    end
    if (cmd.cap_next) begin
      cv_next_r <= code;
    end
    if (cmd.out_load) begin
      cur_out_r <= 3'(playing_r);
      nxt_out_r <= 3'(pending_r);
      cvn_out_r <= cv_now_r;
      cvx_out_r <= cv_next_r;
    end
  end

  assign out_current_step = cur_out_r;
  assign out_next_step    = nxt_out_r;
  assign out_cv_now       = cvn_out_r;
  assign out_cv_next      = cvx_out_r;

  a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rng_r != 32'd0)
    else $error("random state reached zero");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r <= IW'(STEPS - 1)) && (playing_r <= IW'(STEPS - 1)))
    else $error("step index out of range");

  a_try_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search_try |-> (tries_r < TW'(STEPS)))
    else $error("search ran past its try limit");

  a_bounce_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.search_try && pattern_r == PAT_BOUNCE && k_new == IW'(STEPS - 1)) |=> bounce_r)
    else $error("bounce did not turn at the top step");

endmodule

@@ rtl/core/step_sequencer_with_pitch_quantizer.sv @@
`timescale 1ns / 1ps

// Eight-step CV sequencer with pitch quantizer.
// Input stream (in_*): tuser[0] is the request kind (0 load, 1 advance),
// tdata carries the step index and the 12-bit sample for loads.
// Output stream (out_*): one word per input word with the playing step,
// the pending step and a DAC code for each.
// Config port (cfg_*): index selects pattern mode, quantize mode, octave
// span, octave shift, step enable mask or random seed; always ready and
// meant to be written while no word is in flight.
// Timing: a word is accepted in the idle state. An advance whose pattern
// does not hold then runs the try loop: 1 to STEPS skip tries, one per
// cycle. The single read port of the sample memory then reads the
// playing and the pending sample in turn; both pass the three-stage
// scaler and are captured, and the result moves into the output
// register. The next word is accepted from the cycle the result is valid.
// The next word is taken while a finished result still waits; if the
// receiver stalls, the block holds before delivering a second result.
// Reset clears all steps to zero samples, both step indexes to zero,
// the bounce direction to upward and the random state to 2.
module step_sequencer_with_pitch_quantizer #(
  parameter int STEPS    = 8,
  parameter int DAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // step_index[2:0], cv_sample[14:3], zero pad
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // current_step[2:0], next_step[5:3],
                                  // cv_now[17:6], cv_next[29:18], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import ssq_pkg::*;

  ssq_cmd_t    cmd;
  ssq_stat_t   stat;
  logic [2:0]  cur_step;
  logic [2:0]  nxt_step;
  logic [11:0] cv_now;
  logic [11:0] cv_next;

  assign cfg_ready = 1'b1;

  ssq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser[0]),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssq_dp #(
    .STEPS   (STEPS),
    .DAC_BITS(DAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_step_index   (in_tdata[2:0]),
    .in_cv_sample    (in_tdata[14:3]),
    .out_current_step(cur_step),
    .out_next_step   (nxt_step),
    .out_cv_now      (cv_now),
    .out_cv_next     (cv_next)
  );

  // Pack the result word
  assign out_tdata = {2'b00, cv_next, cv_now, nxt_step, cur_step};

endmodule
